>>> hdl/cacs_pkg.sv
// ----------------------------------------------------------------------------
// cacs_pkg
// Shared types and codes for the cave-generation cellular automaton block.
// ----------------------------------------------------------------------------
package cacs_pkg;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_GEN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_BIRTH_LIMIT = 3'd2;
  localparam logic [2:0] CFG_DEATH_LIMIT = 3'd3;
  localparam logic [2:0] CFG_GEN_COUNT   = 3'd4;

  // configuration reset values
  localparam logic [7:0] RST_GRID_WIDTH  = 8'd100;
  localparam logic [7:0] RST_GRID_HEIGHT = 8'd100;
  localparam logic [3:0] RST_BIRTH_LIMIT = 4'd4;
  localparam logic [3:0] RST_DEATH_LIMIT = 4'd3;
  localparam logic [7:0] RST_GEN_COUNT   = 8'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_RD,
    ST_GEN_FIRST,
    ST_GEN_PRIME,
    ST_GEN_ROW,
    ST_EMIT
  } state_t;

  // per-row control handed to the row update logic
  typedef struct packed {
    logic       above_out;   // row above lies outside the grid
    logic       below_out;   // row below lies outside the grid
    logic [3:0] birth_limit;
    logic [3:0] death_limit;
  } row_ctl_t;

endpackage

>>> hdl/cacs_ram.sv
// ----------------------------------------------------------------------------
// cacs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cacs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/cacs_row_update.sv
// ----------------------------------------------------------------------------
// cacs_row_update
// Computes the next state of one full grid row from the old rows above,
// at and below it. Cells outside the grid count as live neighbours.
// ----------------------------------------------------------------------------
module cacs_row_update #(
  parameter int COLS = 128,
  localparam int CNT_W = $clog2(COLS + 1)
) (
  input  logic [COLS-1:0]   above_row,
  input  logic [COLS-1:0]   mid_row,
  input  logic [COLS-1:0]   below_row,
  input  logic [CNT_W-1:0]  cols_use,
  input  cacs_pkg::row_ctl_t ctl,
  output logic [COLS-1:0]   new_row
);

  logic [COLS-1:0] out_mask;
  logic [COLS-1:0] ap;
  logic [COLS-1:0] mp;
  logic [COLS-1:0] bp;

  // columns at or beyond the width in use read as alive
  always_comb begin
    for (int i = 0; i < COLS; i++) begin
      out_mask[i] = (i >= int'(cols_use));
    end
    ap = ctl.above_out ? '1 : (above_row | out_mask);
    mp = mid_row | out_mask;
    bp = ctl.below_out ? '1 : (below_row | out_mask);
  end

  always_comb begin
    logic [3:0] n;
    logic       al, ar, ml, mr, bl, br;
    for (int i = 0; i < COLS; i++) begin
      al = (i == 0) ? 1'b1 : ap[(i == 0) ? 0 : i - 1];
      ml = (i == 0) ? 1'b1 : mp[(i == 0) ? 0 : i - 1];
      bl = (i == 0) ? 1'b1 : bp[(i == 0) ? 0 : i - 1];
      ar = (i == COLS - 1) ? 1'b1 : ap[(i == COLS - 1) ? i : i + 1];
      mr = (i == COLS - 1) ? 1'b1 : mp[(i == COLS - 1) ? i : i + 1];
      br = (i == COLS - 1) ? 1'b1 : bp[(i == COLS - 1) ? i : i + 1];
      n = 4'(al) + 4'(ap[i]) + 4'(ar) + 4'(ml) + 4'(mr) + 4'(bl) + 4'(bp[i]) + 4'(br);
      if (out_mask[i]) begin
        new_row[i] = mid_row[i];
      end else if (mid_row[i]) begin
        new_row[i] = !(n < ctl.death_limit);
      end else begin
        new_row[i] = (n > ctl.birth_limit);
      end
    end
  end

endmodule

>>> hdl/cellular_automaton_cave_step_core.sv
// ----------------------------------------------------------------------------
// cellular_automaton_cave_step_core
// Cave-generation cellular automaton over a grid held in a row-wide RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command items (write cell, generate, read cell), valid/ready.
//   out_* : one result item per command (kind echo, cell state for reads).
//   cfg_* : register writes, always ready; write only while the block idles.
// The grid is stored one row per RAM word. Write and read items read the
// row on acceptance, write or sample it (ST_WR, ST_RD), then emit. A
// generate item sweeps the grid one row per cycle after priming
// (ST_GEN_FIRST, ST_GEN_PRIME) for each generation. The sweep rate is set
// by the single RAM read port: the above and current rows are registered
// and the row below comes from the RAM, so the update runs in place.
// Results wait in an output register; when the receiver stalls the block
// holds the next finished result and takes no new item until it moves.
// A new item is accepted while an earlier result still waits to be taken.
// Reset restores config and state registers; the grid RAM is not cleared
// and every cell in use must be written before the first generate.
// ----------------------------------------------------------------------------
module cellular_automaton_cave_step_core #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  // command items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [6:0] in_column,
  input  logic [6:0] in_row,
  input  logic       in_cell_value,
  // result items
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_done_kind,
  output logic       out_cell_alive,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);

  cacs_pkg::state_t state_r, state_nxt;

  logic [7:0]  grid_width_r, grid_height_r, gen_count_r;
  logic [3:0]  birth_limit_r, death_limit_r;

  logic [1:0]       kind_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] irow_r;
  logic             val_r;
  logic             inside_r;
  logic             res_alive_r;

  logic [ROW_W-1:0] sweep_row_r, sweep_row_nxt;
  logic [7:0]       gens_left_r, gens_left_nxt;
  logic [MAX_COLUMNS-1:0] prev_row_r, cur_row_r;

  logic       out_valid_r;
  logic [1:0] out_done_kind_r;
  logic       out_cell_alive_r;

  logic [CCNT_W-1:0] cols_use;
  logic [RCNT_W-1:0] rows_use;
  logic              in_inside;
  logic              in_acc;
  logic              out_free;
  logic              last_row;
  logic              gen_runs;

  logic                   ram_we;
  logic [ROW_W-1:0]       ram_waddr;
  logic [MAX_COLUMNS-1:0] ram_wdata;
  logic [ROW_W-1:0]       ram_raddr;
  logic [MAX_COLUMNS-1:0] ram_rdata;
  logic [MAX_COLUMNS-1:0] new_row;
  logic [MAX_COLUMNS-1:0] wr_row;
  cacs_pkg::row_ctl_t     row_ctl;

  // ---- grid size in use, clamped to the storage ----
  assign cols_use = (32'(grid_width_r) > MAX_COLUMNS) ? CCNT_W'(MAX_COLUMNS)
                                                      : CCNT_W'(grid_width_r);
  assign rows_use = (32'(grid_height_r) > MAX_ROWS) ? RCNT_W'(MAX_ROWS)
                                                    : RCNT_W'(grid_height_r);

  assign in_inside = (32'(in_column) < 32'(cols_use)) && (32'(in_row) < 32'(rows_use));
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign last_row  = (32'(sweep_row_r) + 32'd1) >= 32'(rows_use);
  assign gen_runs  = (gen_count_r != 8'd0) && (rows_use != '0) && (cols_use != '0);

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= cacs_pkg::RST_GRID_WIDTH;
      grid_height_r <= cacs_pkg::RST_GRID_HEIGHT;
      birth_limit_r <= cacs_pkg::RST_BIRTH_LIMIT;
      death_limit_r <= cacs_pkg::RST_DEATH_LIMIT;
      gen_count_r   <= cacs_pkg::RST_GEN_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cacs_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        cacs_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        cacs_pkg::CFG_BIRTH_LIMIT: birth_limit_r <= cfg_data[3:0];
        cacs_pkg::CFG_DEATH_LIMIT: death_limit_r <= cfg_data[3:0];
        cacs_pkg::CFG_GEN_COUNT:   gen_count_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cacs_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            cacs_pkg::KIND_WRITE: state_nxt = cacs_pkg::ST_WR;
            cacs_pkg::KIND_READ:  state_nxt = cacs_pkg::ST_RD;
            cacs_pkg::KIND_GEN:   state_nxt = gen_runs ? cacs_pkg::ST_GEN_FIRST
                                                       : cacs_pkg::ST_EMIT;
            default:              state_nxt = cacs_pkg::ST_EMIT;
          endcase
        end
      end
      cacs_pkg::ST_WR:        state_nxt = cacs_pkg::ST_EMIT;
      cacs_pkg::ST_RD:        state_nxt = cacs_pkg::ST_EMIT;
      cacs_pkg::ST_GEN_FIRST: state_nxt = cacs_pkg::ST_GEN_PRIME;
      cacs_pkg::ST_GEN_PRIME: state_nxt = cacs_pkg::ST_GEN_ROW;
      cacs_pkg::ST_GEN_ROW: begin
        if (last_row) begin
          state_nxt = (gens_left_r == 8'd1) ? cacs_pkg::ST_EMIT : cacs_pkg::ST_GEN_FIRST;
        end
      end
      cacs_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = cacs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cacs_pkg::ST_IDLE;
    endcase
  end

  // ---- control outputs ----
  always_comb begin
    wr_row         = ram_rdata;
    wr_row[col_r]  = val_r;
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = irow_r;
    ram_wdata      = wr_row;
    ram_raddr      = '0;
    sweep_row_nxt  = sweep_row_r;
    gens_left_nxt  = gens_left_r;
    row_ctl.above_out   = (sweep_row_r == '0);
    row_ctl.below_out   = last_row;
    row_ctl.birth_limit = birth_limit_r;
    row_ctl.death_limit = death_limit_r;
    case (state_r)
      cacs_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = in_inside ? ROW_W'(32'(in_row)) : '0;
        if (in_acc) begin
          gens_left_nxt = gen_count_r;
        end
      end
      cacs_pkg::ST_WR: begin
        ram_we = inside_r;
      end
      cacs_pkg::ST_GEN_FIRST: begin
        ram_raddr     = '0;
        sweep_row_nxt = '0;
      end
      cacs_pkg::ST_GEN_PRIME: begin
        ram_raddr = (32'(rows_use) > 32'd1) ? ROW_W'(1) : '0;
      end
      cacs_pkg::ST_GEN_ROW: begin
        // row above and current row come from registers; below from the RAM
        ram_we    = 1'b1;
        ram_waddr = sweep_row_r;
        ram_wdata = new_row;
        ram_raddr = ((32'(sweep_row_r) + 32'd2) < 32'(rows_use))
                    ? ROW_W'(32'(sweep_row_r) + 32'd2) : '0;
        if (last_row) begin
          sweep_row_nxt = '0;
          gens_left_nxt = gens_left_r - 8'd1;
        end else begin
          sweep_row_nxt = ROW_W'(32'(sweep_row_r) + 32'd1);
        end
      end
      default: ;
    endcase
  end

  // ---- state and datapath registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cacs_pkg::ST_IDLE;
      gens_left_r <= '0;
      sweep_row_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gens_left_r <= gens_left_nxt;
      sweep_row_r <= sweep_row_nxt;
      if (state_r == cacs_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r      <= in_kind;
      col_r       <= in_inside ? COL_W'(32'(in_column)) : '0;
      irow_r      <= in_inside ? ROW_W'(32'(in_row)) : '0;
      val_r       <= in_cell_value;
      inside_r    <= in_inside;
      res_alive_r <= 1'b0;
    end
    if (state_r == cacs_pkg::ST_RD) begin
      res_alive_r <= inside_r ? ram_rdata[col_r] : 1'b0;
    end
    if (state_r == cacs_pkg::ST_GEN_PRIME) begin
      cur_row_r <= ram_rdata;
    end
    if (state_r == cacs_pkg::ST_GEN_ROW) begin
      prev_row_r <= cur_row_r;
      cur_row_r  <= ram_rdata;
    end
    if (state_r == cacs_pkg::ST_EMIT && out_free) begin
      out_done_kind_r  <= kind_r;
      out_cell_alive_r <= res_alive_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_done_kind  = out_done_kind_r;
  assign out_cell_alive = out_cell_alive_r;

  // ---- grid storage and row update ----
  cacs_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cacs_row_update #(
    .COLS (MAX_COLUMNS)
  ) u_row_update (
    .above_row (prev_row_r),
    .mid_row   (cur_row_r),
    .below_row (ram_rdata),
    .cols_use  (cols_use),
    .ctl       (row_ctl),
    .new_row   (new_row)
  );

`ifndef SYNTH
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == cacs_pkg::ST_WR || state_r == cacs_pkg::ST_GEN_ROW))
    else $error("grid write outside a write or sweep cycle");

  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cacs_pkg::ST_GEN_ROW |->
      (32'(sweep_row_r) < 32'(rows_use)) && (gens_left_r != 8'd0))
    else $error("sweep row or generation count out of range");

  a_gen_decrement: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cacs_pkg::ST_GEN_ROW && state_nxt == cacs_pkg::ST_GEN_FIRST) |=>
      gens_left_r == $past(gens_left_r) - 8'd1)
    else $error("generation counter did not step");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cacs_pkg::ST_EMIT && out_free) |=>
      (out_valid_r && state_r == cacs_pkg::ST_IDLE))
    else $error("finished item not moved to the output register");
`endif

endmodule
